/* src/assert_macros.svh */
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check prop at every rising edge once reset is released.
`define ASSERT_CLK(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("assertion failed");

// Check prop at every rising edge, reset included.
`define ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) else $error("assertion failed");

`endif

/* src/swmd_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
package swmd_pkg;
    localparam int WINDOW_MAX  = 32;
    localparam int SAMPLE_BITS = 16;
    localparam int LEN_W       = 6;                       // config field width
    localparam int DEV_BITS    = 21;
    localparam int LEN_RESET   = 8;
    localparam int IDX_W       = $clog2(WINDOW_MAX);
    localparam int CNT_W       = $clog2(WINDOW_MAX + 1);  // holds 0..WINDOW_MAX
    localparam int SUM_W       = SAMPLE_BITS + IDX_W + 1; // signed window sum
    localparam int MAG_W       = SUM_W - 1;               // magnitude of the sum
    localparam int DIFF_W      = SAMPLE_BITS + 1;         // entry minus mean
    localparam int DACC_W      = DIFF_W + IDX_W + 1;      // deviation accumulator

    typedef logic signed [SAMPLE_BITS-1:0] sample_t;
endpackage
`default_nettype wire

/* src/swmd_cell.sv */
`timescale 1ns / 1ps
`default_nettype none
module swmd_cell
    import swmd_pkg::*;
(
    input  wire logic    aclk,
    input  wire logic    aresetn,
    input  wire logic    shift_en,
    input  wire logic    active,
    input  wire sample_t d_in,
    output sample_t      q
);
    sample_t value_reg;

    // take the neighbor's word only while inside the window
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            value_reg <= '0;
        end else if (shift_en && active) begin
            value_reg <= d_in;
        end
    end

    assign q = value_reg;
endmodule
`default_nettype wire

/* src/swmd_div.sv */
`timescale 1ns / 1ps
`default_nettype none
module swmd_div
    import swmd_pkg::*;
(
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             start,
    input  wire logic [MAG_W-1:0] dividend,
    input  wire logic [CNT_W-1:0] divisor,
    output logic                  done,
    output logic [MAG_W-1:0]      quotient
);
    localparam int STEP_W = $clog2(MAG_W);

    logic [CNT_W-1:0]  rem_reg;
    logic [MAG_W-1:0]  quo_reg;
    logic [STEP_W-1:0] step_reg;
    logic              busy_reg;
    logic              done_reg;
    logic [CNT_W:0]    trial;
    logic              fits;

    // restoring division, one quotient bit per cycle
    assign trial = {rem_reg, quo_reg[MAG_W-1]};
    assign fits  = trial >= {1'b0, divisor};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                rem_reg  <= '0;
                quo_reg  <= dividend;
                step_reg <= STEP_W'(MAG_W - 1);
            end else if (busy_reg) begin
                rem_reg  <= fits ? CNT_W'(trial - {1'b0, divisor}) : trial[CNT_W-1:0];
                quo_reg  <= {quo_reg[MAG_W-2:0], fits};
                step_reg <= step_reg - 1'b1;
                if (step_reg == '0) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;
endmodule
`default_nettype wire

/* src/sliding_window_mean_deviation.sv */
// From an accepted word to the result word, the block walks twice around the cell ring
// (sum, then deviation) over the L cells of the window, L being the window length, and
// runs a 21-step serial divider between the two walks.
// Words are taken one at a time; the next word is taken once the result
// sits in the output register. Reset (aresetn low, synchronous) clears the window
// cells, fill count and ready flag, and sets the window length to 8.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module sliding_window_mean_deviation
    import swmd_pkg::*;
(
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                cfg_wr_en,
    input  wire logic [LEN_W-1:0]    cfg_wr_data,
    input  wire logic                s_valid,
    output logic                     s_ready,
    input  wire sample_t             s_sample,
    output logic                     m_valid,
    input  wire logic                m_ready,
    output sample_t                  m_window_mean,
    output logic [DEV_BITS-1:0]      m_deviation_sum,
    output logic                     m_window_complete,
    output logic                     m_window_ready
);
    typedef enum logic [2:0] {
        ST_IDLE, ST_SUM, ST_DIVGO, ST_DIV, ST_DEV, ST_OUT
    } state_t;

    state_t                state_reg;
    logic [CNT_W-1:0]      len_reg;
    logic [CNT_W-1:0]      fill_reg;
    logic                  ready_flag_reg;
    logic                  complete_reg;
    logic [CNT_W-1:0]      pass_reg;
    logic signed [SUM_W-1:0] sum_reg;
    sample_t               mean_reg;
    logic [DACC_W-1:0]     dev_reg;
    logic                  m_valid_reg;
    sample_t               m_mean_reg;
    logic [DEV_BITS-1:0]   m_dev_reg;
    logic                  m_complete_reg;
    logic                  m_ready_flag_reg;

    logic                  accept;
    logic                  shift_en;
    sample_t               head;
    sample_t               tail;
    sample_t               cell_q [WINDOW_MAX];
    logic [WINDOW_MAX-1:0] cell_active;
    logic [CNT_W-1:0]      len_next;
    logic [CNT_W-1:0]      fill_next;
    logic [CNT_W-1:0]      len_m1;
    logic                  div_start;
    logic                  div_done;
    logic [MAG_W-1:0]      div_quo;
    logic [MAG_W-1:0]      sum_mag;
    logic signed [SUM_W-1:0] mean_full;
    logic signed [DIFF_W-1:0] diff;
    logic [DIFF_W-1:0]     diff_abs;
    logic                  out_free;

    assign accept    = s_valid && s_ready;
    // hold off the input word while a length write lands
    assign s_ready   = state_reg == ST_IDLE && !cfg_wr_en;
    assign out_free  = !m_valid_reg || m_ready;
    assign shift_en  = accept || state_reg == ST_SUM || state_reg == ST_DEV;
    assign head      = accept ? s_sample : tail;
    assign len_m1    = len_reg - 1'b1;
    assign fill_next = fill_reg + 1'b1;
    assign div_start = state_reg == ST_DIVGO;

    // clamp the written length to 1..WINDOW_MAX
    always_comb begin
        if (cfg_wr_data == '0) begin
            len_next = CNT_W'(1);
        end else if (32'(cfg_wr_data) > 32'(WINDOW_MAX)) begin
            len_next = CNT_W'(WINDOW_MAX);
        end else begin
            len_next = CNT_W'(cfg_wr_data);
        end
    end

    // pick the oldest word in the window; it wraps back to cell 0 while walking
    always_comb begin
        tail = '0;
        for (int i = 0; i < WINDOW_MAX; i++) begin
            if (IDX_W'(i) == len_m1[IDX_W-1:0]) begin
                tail = cell_q[i];
            end
        end
    end

    genvar g;
    generate
        for (g = 0; g < WINDOW_MAX; g++) begin : g_cell
            assign cell_active[g] = CNT_W'(g) < len_reg;
            if (g == 0) begin : g_head
                swmd_cell u_cell (
                    .aclk     (aclk),
                    .aresetn  (aresetn),
                    .shift_en (shift_en),
                    .active   (cell_active[g]),
                    .d_in     (head),
                    .q        (cell_q[g])
                );
            end else begin : g_body
                swmd_cell u_cell (
                    .aclk     (aclk),
                    .aresetn  (aresetn),
                    .shift_en (shift_en),
                    .active   (cell_active[g]),
                    .d_in     (cell_q[g-1]),
                    .q        (cell_q[g])
                );
            end
        end
    endgenerate

    assign sum_mag = sum_reg[SUM_W-1] ? MAG_W'(-sum_reg) : MAG_W'(sum_reg);

    swmd_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (sum_mag),
        .divisor  (len_reg),
        .done     (div_done),
        .quotient (div_quo)
    );

    // apply the sum's sign to the magnitude quotient: truncation toward zero
    assign mean_full = sum_reg[SUM_W-1] ? -$signed({1'b0, div_quo}) : $signed({1'b0, div_quo});
    assign diff      = DIFF_W'(tail) - DIFF_W'(mean_reg);
    assign diff_abs  = diff[DIFF_W-1] ? DIFF_W'(-diff) : DIFF_W'(diff);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            len_reg        <= CNT_W'(LEN_RESET);
            fill_reg       <= '0;
            ready_flag_reg <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            if (m_valid_reg && m_ready && state_reg != ST_OUT) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (cfg_wr_en) begin
                        if (len_next != len_reg) begin
                            ready_flag_reg <= 1'b0;
                        end
                        len_reg <= len_next;
                        if (fill_reg >= len_next) begin
                            fill_reg <= '0;
                        end
                    end else if (accept) begin
                        if (fill_next == len_reg) begin
                            fill_reg       <= '0;
                            complete_reg   <= 1'b1;
                            ready_flag_reg <= 1'b1;
                        end else begin
                            fill_reg     <= fill_next;
                            complete_reg <= 1'b0;
                        end
                        sum_reg   <= '0;
                        pass_reg  <= len_m1;
                        state_reg <= ST_SUM;
                    end
                end
                ST_SUM: begin
                    sum_reg  <= sum_reg + SUM_W'(tail);
                    pass_reg <= pass_reg - 1'b1;
                    if (pass_reg == '0) begin
                        state_reg <= ST_DIVGO;
                    end
                end
                ST_DIVGO: begin
                    state_reg <= ST_DIV;
                end
                ST_DIV: begin
                    if (div_done) begin
                        mean_reg  <= mean_full[SAMPLE_BITS-1:0];
                        dev_reg   <= '0;
                        pass_reg  <= len_m1;
                        state_reg <= ST_DEV;
                    end
                end
                ST_DEV: begin
                    dev_reg  <= dev_reg + DACC_W'(diff_abs);
                    pass_reg <= pass_reg - 1'b1;
                    if (pass_reg == '0) begin
                        state_reg <= ST_OUT;
                    end
                end
                ST_OUT: begin
                    // hold until the output register is free
                    if (out_free) begin
                        m_valid_reg      <= 1'b1;
                        m_mean_reg       <= mean_reg;
                        m_dev_reg        <= (dev_reg > DACC_W'({DEV_BITS{1'b1}})) ?
                                            {DEV_BITS{1'b1}} : dev_reg[DEV_BITS-1:0];
                        m_complete_reg   <= complete_reg;
                        m_ready_flag_reg <= ready_flag_reg;
                        state_reg        <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign m_valid           = m_valid_reg;
    assign m_window_mean     = m_mean_reg;
    assign m_deviation_sum   = m_dev_reg;
    assign m_window_complete = m_complete_reg;
    assign m_window_ready    = m_ready_flag_reg;

    `ASSERT_CLK(a_fill_below_len, aclk, aresetn, fill_reg < len_reg)
    `ASSERT_CLK(a_len_in_range, aclk, aresetn,
        len_reg >= CNT_W'(1) && len_reg <= CNT_W'(WINDOW_MAX))
    `ASSERT_CLK(a_one_at_a_time, aclk, aresetn, accept |=> !s_ready)
    `ASSERT_CLK(a_complete_sets_ready, aclk, aresetn,
        (m_valid && m_window_complete) |-> m_window_ready)
endmodule
`default_nettype wire
